FILE: sv/psm_pkg.sv
// Package: shared types and constants of the program stream map parser.
`default_nettype none
package psm_pkg;
  localparam logic [7:0] EXT_STREAM_ID = 8'hFD;
  localparam logic [15:0] MIN_MAP_LEN = 16'd10;
  localparam logic [15:0] MIN_EXT_INFO = 16'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MORE = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] codec_type;
    logic [7:0] stream_ident;
    logic [3:0] slot_index;
    logic       is_new;
    logic [1:0] status_code;
    logic [4:0] map_version;
    logic [4:0] stored_count;
  } out_item_t;

  // Work handed from the front to the back: an entry to store, plus an
  // optional status on the same byte that replaces the entry result.
  typedef struct packed {
    logic       has_entry;
    logic       has_status;
    logic [1:0] status;
    logic [7:0] etype;
    logic [7:0] eid;
    logic [4:0] version;
  } job_t;
endpackage
`default_nettype wire

FILE: sv/psm_if.sv
// Interfaces: valid/ready stream channels for input bytes and results.
`default_nettype none
interface psm_in_if;
  logic                valid;
  logic                ready;
  psm_pkg::in_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface psm_out_if;
  logic                valid;
  logic                ready;
  psm_pkg::out_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/psm_front.sv
// Front end: byte parser that classifies each byte and issues table jobs.
`default_nettype none
module psm_front #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire psm_pkg::in_item_t in_item,
  input  wire logic              q_full,
  input  wire logic              q_pending,
  output logic                   job_valid,
  output psm_pkg::job_t          job,
  input  wire logic [6:0]        est_count
);
  localparam logic [3:0] PH_IDLE = 4'd0, PH_LEN_LO = 4'd1, PH_HEAD = 4'd2,
    PH_INFO = 4'd3, PH_ESMAP = 4'd4, PH_TYPE = 4'd5, PH_ID = 4'd6, PH_LHI = 4'd7,
    PH_LLO = 4'd8, PH_SKIP = 4'd9, PH_TAIL = 4'd10, PH_BAD = 4'd11,
    PH_DECIDE = 4'd12;
  localparam logic [6:0] TABLE_N = 7'(TABLE_ENTRIES);

  logic [3:0] phase, phase_next;
  logic [15:0] pos, sec_len, sec_len_next, info_len, info_len_next;
  logic [15:0] end_pos, end_pos_next;
  logic [7:0] ptype, ptype_next, pid, pid_next;
  logic ext_flag, ext_flag_next;
  logic [4:0] version, version_next;
  logic fire;
  logic [16:0] n, region_end, lim;

  // A byte that may start an entry header waits until every earlier job has
  // left the queue, so that the table fill it depends on is final.
  assign in_ready = !q_full && !(phase == PH_DECIDE && q_pending);
  assign fire = in_valid && in_ready;

  always_comb begin
    n = {1'b0, pos} + 17'd1;
    region_end = {1'b0, sec_len} - 17'd4;
    lim = n + {1'b0, info_len_next};
  end

  always_comb begin
    phase_next = phase;
    sec_len_next = sec_len;
    info_len_next = info_len;
    end_pos_next = end_pos;
    ptype_next = ptype;
    pid_next = pid;
    ext_flag_next = ext_flag;
    version_next = version;
    job = '0;
    if (in_item.section_start) begin
      sec_len_next = {in_item.data_byte, 8'd0};
      phase_next = PH_LEN_LO;
    end else if (phase == PH_LEN_LO) begin
      sec_len_next = {sec_len[15:8], in_item.data_byte};
      if (sec_len_next == 16'd0) begin
        job.has_status = 1'b1;
        job.status = psm_pkg::ST_BAD;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_HEAD;
      end
    end else if (phase != PH_IDLE) begin
      unique case (phase)
        PH_HEAD: begin
          if (pos == 16'd0) begin
            ext_flag_next = in_item.data_byte[6];
            version_next = in_item.data_byte[4:0];
          end else if (pos == 16'd2) begin
            info_len_next = {in_item.data_byte, 8'd0};
          end else if (pos == 16'd3) begin
            info_len_next = {info_len[15:8], in_item.data_byte};
            if ({1'b0, info_len_next} + 17'd10 > {1'b0, sec_len}) begin
              phase_next = PH_BAD;
            end else if (info_len_next == 16'd0) begin
              phase_next = PH_ESMAP;
              end_pos_next = 16'(n + 17'd2);
            end else begin
              phase_next = PH_INFO;
              end_pos_next = 16'(lim);
            end
          end
        end
        PH_INFO: begin
          if (n >= {1'b0, end_pos}) begin
            phase_next = PH_ESMAP;
            end_pos_next = 16'(n + 17'd2);
          end
        end
        PH_ESMAP, PH_SKIP: begin
          if (n >= {1'b0, end_pos}) phase_next = PH_DECIDE;
        end
        PH_DECIDE: begin
          // This byte is either the type byte of another entry or tail.
          if ({1'b0, pos} + 17'd4 <= region_end && est_count < TABLE_N) begin
            ptype_next = in_item.data_byte;
            phase_next = PH_ID;
          end else begin
            phase_next = PH_TAIL;
          end
        end
        PH_TYPE: begin
          ptype_next = in_item.data_byte;
          phase_next = PH_ID;
        end
        PH_ID: begin
          pid_next = in_item.data_byte;
          phase_next = PH_LHI;
        end
        PH_LHI: begin
          info_len_next = {in_item.data_byte, 8'd0};
          phase_next = PH_LLO;
        end
        PH_LLO: begin
          info_len_next = {info_len[15:8], in_item.data_byte};
          if (lim > region_end) begin
            phase_next = PH_BAD;
          end else begin
            job.has_entry = 1'b1;
            if (pid == psm_pkg::EXT_STREAM_ID && !ext_flag &&
                info_len_next < psm_pkg::MIN_EXT_INFO) begin
              phase_next = PH_BAD;
            end else if (info_len_next == 16'd0) begin
              phase_next = PH_DECIDE;
            end else begin
              end_pos_next = 16'(lim);
              phase_next = PH_SKIP;
            end
          end
        end
        default: ;
      endcase
      if ({1'b0, pos} == {1'b0, sec_len} - 17'd1) begin
        job.has_status = 1'b1;
        job.status = (phase_next == PH_BAD || sec_len < psm_pkg::MIN_MAP_LEN)
                     ? psm_pkg::ST_BAD : psm_pkg::ST_OK;
        phase_next = PH_IDLE;
      end
    end
    if (!job.has_status && in_item.buffer_end && phase_next != PH_IDLE) begin
      job.has_status = 1'b1;
      job.status = psm_pkg::ST_MORE;
      phase_next = PH_IDLE;
    end
    job.etype = ptype;
    job.eid = pid;
    job.version = version_next;
  end

  assign job_valid = fire && (job.has_entry || job.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      sec_len <= '0;
      info_len <= '0;
      end_pos <= '0;
      ptype <= '0;
      pid <= '0;
      ext_flag <= 1'b0;
      version <= '0;
    end else begin
      if (fire) begin
        phase <= phase_next;
        sec_len <= sec_len_next;
        info_len <= info_len_next;
        end_pos <= end_pos_next;
        ptype <= ptype_next;
        pid <= pid_next;
        ext_flag <= ext_flag_next;
        version <= version_next;
        if (!in_item.section_start && phase == PH_LEN_LO) pos <= '0;
        else if (!in_item.section_start && phase != PH_IDLE) pos <= 16'(n);
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/psm_queue.sv
// Job queue: small FIFO between the parser front end and the table back end.
`default_nettype none
module psm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire psm_pkg::job_t push_job,
  output logic               full,
  output logic               not_empty,
  input  wire logic          pop,
  output psm_pkg::job_t      head
);
  psm_pkg::job_t slots [4];
  logic [1:0] wr, rd;
  logic [2:0] fill;
  assign full = fill >= 3'd3;  // room for the byte in flight
  assign not_empty = fill != 3'd0;
  assign head = slots[rd];
  always_ff @(posedge clk) begin
    if (push) slots[wr] <= push_job;
    if (rst) begin
      wr <= '0;
      rd <= '0;
      fill <= '0;
    end else begin
      if (push) wr <= wr + 2'd1;
      if (pop) rd <= rd + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: sv/psm_back.sv
// Back end: serial id table lookup, table update and result register.
`default_nettype none
module psm_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_avail,
  input  wire psm_pkg::job_t job,
  output logic               job_pop,
  output logic [6:0]         used_count,
  output logic               res_valid,
  input  wire logic          res_ready,
  output psm_pkg::out_item_t res
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [6:0] TABLE_N = 7'(TABLE_ENTRIES);

  logic [7:0] id_mem [TABLE_ENTRIES];
  logic [6:0] used;
  logic [6:0] scan;
  logic busy;
  logic [7:0] rd_id;
  logic hit;
  logic [6:0] slot;

  assign used_count = used;
  assign hit = busy && scan < used && rd_id == job.eid;

  // One table slot read per cycle; rd_id belongs to slot scan.
  always_ff @(posedge clk) begin
    rd_id <= id_mem[IW'(busy ? scan + 7'd1 : 7'd0)];
  end

  always_comb begin
    job_pop = 1'b0;
    slot = hit ? scan : used;
    if (job_avail && !res_valid) begin
      if (!job.has_entry) job_pop = 1'b1;
      else if (busy && (hit || scan >= used)) job_pop = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop && job.has_entry && slot < TABLE_N) begin
      id_mem[IW'(slot)] <= job.eid;
    end
    if (job_pop) begin
      res.result_kind <= job.has_status;
      res.codec_type <= job.has_status ? 8'd0 : job.etype;
      res.stream_ident <= job.has_status ? 8'd0 : job.eid;
      res.slot_index <= job.has_status ? 4'd0 : 4'(slot);
      res.is_new <= !job.has_status && !hit;
      res.status_code <= job.has_status ? job.status : psm_pkg::ST_OK;
      res.map_version <= job.version;
      res.stored_count <= 5'(used + ((job.has_entry && !hit) ? 7'd1 : 7'd0));
    end
    if (rst) begin
      used <= '0;
      busy <= 1'b0;
      scan <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (job_pop) begin
        res_valid <= 1'b1;
        busy <= 1'b0;
        scan <= '0;
        if (job.has_entry && !hit) used <= used + 7'd1;
      end else if (job_avail && job.has_entry && !res_valid) begin
        if (busy) scan <= scan + 7'd1;
        busy <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/program_stream_map_parser.sv
// Top level: program stream map parser with decoupled parser and table back end.
// A status result passes through the job queue and the result register; an entry result
// also waits for the id table scan up to the matching slot or, for a new id, over the
// entries in use (one table slot read per cycle), once the result register is free. One
// byte per cycle unless the queue is full; a byte that may open an entry header waits until
// the queue has drained. Reset (rst, synchronous) empties the table and idles the parser.
`default_nettype none
module program_stream_map_parser #(
  parameter int TABLE_ENTRIES = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  psm_in_if.sink     in_ch,
  psm_out_if.source  out_ch
);
  // The front end classifies bytes and pushes a job for each byte that makes
  // a result; the back end scans the id table and registers the result.
  // Whether another entry follows depends on the table fill, so the front
  // end holds that byte until the back end has finished all earlier jobs.
  logic q_full, q_ne, job_valid, job_pop;
  psm_pkg::job_t job, head;
  logic [6:0] used;

  psm_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_ch.payload), .q_full, .q_pending(q_ne), .job_valid, .job,
    .est_count(used));

  psm_queue u_queue (
    .clk, .rst, .push(job_valid), .push_job(job), .full(q_full),
    .not_empty(q_ne), .pop(job_pop), .head);

  psm_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .job_avail(q_ne), .job(head), .job_pop, .used_count(used),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.payload));
endmodule
`default_nettype wire

FILE: sv/psm_checker.sv
// Checker: port-level properties of the map parser, bound to the top level.
`default_nettype none
module psm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire psm_pkg::out_item_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.result_kind |-> out_payload.status_code != 2'd3)
    else $error("bad status code");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.result_kind |-> out_payload.stored_count != 5'd0)
    else $error("entry with empty table");
endmodule

bind program_stream_map_parser psm_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload));
`default_nettype wire

FILE: tb/sv/psm_if.sv
// Stream interfaces of the testbench are the ones compiled with the design.

FILE: tb/sv/tb_program_stream_map_parser.sv
// Testbench: drives program stream maps into the parser and checks every result.
`default_nettype none
module tb_program_stream_map_parser;
  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 20000;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_IDLE, P_LEN_LO, P_HEAD, P_INFO, P_ESMAP, P_TYPE, P_ID, P_LHI, P_LLO,
    P_ESKIP, P_TAIL, P_BAD
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  psm_in_if in_ch ();
  psm_out_if out_ch ();

  program_stream_map_parser #(.TABLE_ENTRIES(SLOTS)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state: a private copy of everything the parser remembers.
  logic [7:0]  pr_ids [SLOTS];
  logic [4:0]  pr_used;
  phase_t      pr_phase;
  logic [15:0] pr_pos, pr_len, pr_info, pr_end;
  logic [7:0]  pr_type, pr_id;
  logic        pr_ext;
  logic [4:0]  pr_ver;

  psm_pkg::in_item_t  byte_queue[$];
  psm_pkg::out_item_t expected_results[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        in_took = 1'b0;

  // Chooses, at offset n, between another entry header and the tail.
  function automatic phase_t entry_or_tail(int unsigned n);
    if (n + 4 <= int'(pr_len) - 4 && pr_used < SLOTS) return P_TYPE;
    return P_TAIL;
  endfunction

  // Advances the predictor by one accepted byte and queues the result, if any.
  task automatic predict_byte(input psm_pkg::in_item_t it);
    int                 st;
    bit                 got_entry;
    int unsigned        o, n, slot;
    bit                 fresh;
    psm_pkg::out_item_t r;
    st = -1;
    got_entry = 0;
    slot = 0;
    fresh = 0;
    if (it.section_start) begin
      pr_len = {it.data_byte, 8'h00};
      pr_phase = P_LEN_LO;
    end else if (pr_phase == P_LEN_LO) begin
      pr_len[7:0] = it.data_byte;
      pr_pos = '0;
      if (pr_len == 0) begin
        st = psm_pkg::ST_BAD;
        pr_phase = P_IDLE;
      end else begin
        pr_phase = P_HEAD;
      end
    end else if (pr_phase != P_IDLE) begin
      o = pr_pos;
      n = o + 1;
      case (pr_phase)
        P_HEAD: begin
          if (o == 0) begin
            pr_ext = it.data_byte[6];
            pr_ver = it.data_byte[4:0];
          end else if (o == 2) begin
            pr_info = {it.data_byte, 8'h00};
          end else if (o == 3) begin
            pr_info[7:0] = it.data_byte;
            if (int'(pr_info) + int'(psm_pkg::MIN_MAP_LEN) > int'(pr_len)) begin
              pr_phase = P_BAD;
            end else begin
              pr_end = 16'(n + pr_info);
              pr_phase = P_INFO;
              if (n >= n + pr_info) begin
                pr_phase = P_ESMAP;
                pr_end = 16'(n + 2);
              end
            end
          end
        end
        P_INFO: begin
          if (n >= pr_end) begin
            pr_phase = P_ESMAP;
            pr_end = 16'(n + 2);
          end
        end
        P_ESMAP: if (n >= pr_end) pr_phase = entry_or_tail(n);
        P_TYPE: begin
          pr_type = it.data_byte;
          pr_phase = P_ID;
        end
        P_ID: begin
          pr_id = it.data_byte;
          pr_phase = P_LHI;
        end
        P_LHI: begin
          pr_info = {it.data_byte, 8'h00};
          pr_phase = P_LLO;
        end
        P_LLO: begin
          pr_info[7:0] = it.data_byte;
          if (int'(n) + int'(pr_info) > int'(pr_len) - 4) begin
            pr_phase = P_BAD;
          end else begin
            slot = pr_used;
            fresh = 1;
            for (int i = 0; i < pr_used; i++) begin
              if (fresh && pr_ids[i] == pr_id) begin
                slot = i;
                fresh = 0;
              end
            end
            if (fresh) pr_used++;
            pr_ids[slot] = pr_id;
            got_entry = 1;
            // The extension stream needs a minimum of info unless the map
            // carries the single-extension flag.
            if (pr_id == psm_pkg::EXT_STREAM_ID && !pr_ext &&
                pr_info < psm_pkg::MIN_EXT_INFO) begin
              pr_phase = P_BAD;
            end else begin
              pr_end = 16'(n + pr_info);
              pr_phase = P_ESKIP;
              if (n >= n + pr_info) pr_phase = entry_or_tail(n);
            end
          end
        end
        P_ESKIP: if (n >= pr_end) pr_phase = entry_or_tail(n);
        default: ;
      endcase
      pr_pos = 16'(n);
      if (o == int'(pr_len) - 1) begin
        st = (pr_phase == P_BAD || pr_len < psm_pkg::MIN_MAP_LEN) ? psm_pkg::ST_BAD
                                                                  : psm_pkg::ST_OK;
        pr_phase = P_IDLE;
      end
    end
    // A buffer that runs out mid-map overrides an entry result on this byte.
    if (st < 0 && it.buffer_end && pr_phase != P_IDLE) begin
      st = psm_pkg::ST_MORE;
      pr_phase = P_IDLE;
    end
    r = '0;
    r.map_version = pr_ver;
    r.stored_count = pr_used;
    if (st >= 0) begin
      r.result_kind = 1'b1;
      r.status_code = 2'(st);
      expected_results.push_back(r);
    end else if (got_entry) begin
      r.codec_type = pr_type;
      r.stream_ident = pr_id;
      r.slot_index = 4'(slot);
      r.is_new = fresh;
      expected_results.push_back(r);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input bit s, input bit e);
    psm_pkg::in_item_t it;
    it.data_byte = b;
    it.section_start = s;
    it.buffer_end = e;
    byte_queue.push_back(it);
  endtask

  // Queues a whole map. Ids come from 0 to id_pool, so a small pool makes updates of known
  // slots frequent; cut >= 0 ends the buffer early at that byte index.
  task automatic put_map(input int n_ent, input int info_len, input bit ext,
                         input int id_pool, input int cut, input int corrupt);
    logic [7:0] body[$];
    int         ilen, total, extra;
    body = {};
    body.push_back({1'b1, ext, 1'b0, 5'($urandom)});
    body.push_back(8'($urandom));
    body.push_back(8'(info_len >> 8));
    body.push_back(8'(info_len));
    repeat (info_len) body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    for (int k = 0; k < n_ent; k++) begin
      ilen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 6);
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(0, 7) == 0) ? psm_pkg::EXT_STREAM_ID
                                                 : 8'($urandom_range(0, id_pool)));
      body.push_back(8'(ilen >> 8));
      body.push_back(8'(ilen));
      repeat (ilen) body.push_back(8'($urandom));
    end
    extra = $urandom_range(0, 2);
    repeat (4 + extra) body.push_back(8'($urandom));
    // Occasionally flip a byte so that length checks fail in many places.
    if (corrupt > 0 && corrupt < body.size()) body[corrupt] = 8'($urandom);
    total = body.size();
    put_byte(8'(total >> 8), 1'b1, 1'b0);
    put_byte(8'(total), 1'b0, 1'b0);
    for (int k = 0; k < total; k++) begin
      put_byte(body[k], 1'b0, (k == cut) || (k == total - 1 && $urandom_range(0, 3) == 0));
      if (k == cut) break;
    end
  endtask

  // Records whether the byte on offer was taken at this rising edge.
  always @(posedge clk) in_took <= !rst && in_ch.valid && in_ch.ready;

  // Driver: bursts of transfers with random gaps, changed at the falling edge.
  // The head of the queue is the byte on offer; it leaves once transferred.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_took) void'(byte_queue.pop_front());
      if (in_ch.valid && !in_took) begin
        // Hold the offered byte until the parser takes it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= byte_queue[0];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls: alternate long ready stretches and random stall phases.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (rst) out_ch.ready <= 1'b0;
    else if (stall_phase < 40) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // Monitor: predicts on accepted bytes and checks accepted results.
  psm_pkg::out_item_t want, got;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.payload);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d status=%0d", got.result_kind, got.status_code);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind) begin
            $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
            error_count++;
          end
          if (got.codec_type !== want.codec_type) begin
            $error("codec_type exp %0h got %0h", want.codec_type, got.codec_type);
            error_count++;
          end
          if (got.stream_ident !== want.stream_ident) begin
            $error("stream_ident exp %0h got %0h", want.stream_ident, got.stream_ident);
            error_count++;
          end
          if (got.slot_index !== want.slot_index) begin
            $error("slot_index exp %0d got %0d", want.slot_index, got.slot_index);
            error_count++;
          end
          if (got.is_new !== want.is_new) begin
            $error("is_new exp %0d got %0d", want.is_new, got.is_new);
            error_count++;
          end
          if (got.status_code !== want.status_code) begin
            $error("status_code exp %0d got %0d", want.status_code, got.status_code);
            error_count++;
          end
          if (got.map_version !== want.map_version) begin
            $error("map_version exp %0d got %0d", want.map_version, got.map_version);
            error_count++;
          end
          if (got.stored_count !== want.stored_count) begin
            $error("stored_count exp %0d got %0d", want.stored_count, got.stored_count);
            error_count++;
          end
        end
      end
      // Watchdog on cycles with no transfer on either side.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_program_stream_map_parser: done, errors");
        $finish;
      end
    end
  end

  initial begin
    pr_used = '0;
    pr_phase = P_IDLE;
    pr_pos = '0;
    pr_len = '0;
    pr_info = '0;
    pr_end = '0;
    pr_type = '0;
    pr_id = '0;
    pr_ext = 1'b0;
    pr_ver = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;

    // Directed: idle bytes, zero length, a map shorter than the header,
    // info past the end, an extension stream with too little info, a full
    // table, and an early buffer end.
    put_byte(8'hFF, 1'b0, 1'b1);
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'h03, 1'b0, 1'b0);
    repeat (3) put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'hFF, 1'b1, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);
    put_map(1, 0, 1'b0, 255, -1, 3);
    put_map(3, 2, 1'b0, 255, -1, 0);
    put_map(20, 0, 1'b1, 40, -1, 0);
    put_map(2, 1, 1'b0, 40, 9, 0);
    put_map(2, 0, 1'b0, 40, 6, 0);

    // Random maps; the table fills early, so most maps update known slots.
    while (byte_queue.size() < 1950) begin
      put_map($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 1),
              ($urandom_range(0, 3) == 0) ? 255 : 20,
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : -1,
              ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (byte_queue.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_program_stream_map_parser: done, clean");
    end else begin
      $display("tb_program_stream_map_parser: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: program_stream_map_parser.f
sv/psm_pkg.sv
sv/psm_if.sv
sv/psm_front.sv
sv/psm_queue.sv
sv/psm_back.sv
sv/program_stream_map_parser.sv
sv/psm_checker.sv
tb/sv/psm_if.sv
tb/sv/tb_program_stream_map_parser.sv
